// File: src/sticky_failover_selector_defines.svh
// Assertion macros used by the selector top module.
`ifndef STICKY_FAILOVER_SELECTOR_DEFINES_SVH
`define STICKY_FAILOVER_SELECTOR_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked out of reset.
`define SFS_ASSERT_IMPL(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, checked out of reset.
`define SFS_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SFS_ASSERT_IMPL(name, clk, rst_n, ante, cons, msg)
`define SFS_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg)
`endif

`endif

// File: src/sfs_pkg.sv
`default_nettype none

package sfs_pkg;

  // Fixed field widths of the request and response channels
  localparam int ModeW      = 2;
  localparam int IdFieldW   = 16;
  localparam int MaskW      = 16;
  localparam int StatusW    = 3;
  localparam int SlotFieldW = 4;

  // Parameter defaults
  localparam int MaxTargetsDef = 16;
  localparam int IdBitsDef     = 16;

  typedef enum logic [ModeW-1:0] {
    ModeAdd     = 2'd0,
    ModeRemove  = 2'd1,
    ModeResolve = 2'd2
  } mode_e;

  typedef enum logic [StatusW-1:0] {
    StChosen  = 3'd0,
    StNone    = 3'd1,
    StAdded   = 3'd2,
    StFull    = 3'd3,
    StRemoved = 3'd4,
    StIgnored = 3'd5
  } status_e;

  // Datapath operations issued by the controller
  typedef enum logic [3:0] {
    DpIdle,
    DpAppend,
    DpRemoveStart,
    DpScanStart,
    DpRead,
    DpNext,
    DpMark,
    DpReadNext,
    DpWrite,
    DpRemoveFix,
    DpScanHit,
    DpScanStep
  } dp_op_e;

  typedef struct packed {
    logic    capture;
    dp_op_e  op;
    logic    set_res;
    status_e res;
    logic    load_out;
  } cmd_t;

  typedef struct packed {
    mode_e mode;
    logic  id_zero;
    logic  full;
    logic  empty;
    logic  match;
    logic  last;
    logic  healthy;
    logic  scan_last;
  } sts_t;

endpackage

`default_nettype wire

// File: src/sfs_req_if.sv
`default_nettype none

interface sfs_req_if;
  logic                          valid;
  logic                          ready;
  logic [sfs_pkg::ModeW-1:0]     mode;
  logic [sfs_pkg::IdFieldW-1:0]  target_id;
  logic [sfs_pkg::MaskW-1:0]     health_mask;

  modport source (output valid, output mode, output target_id, output health_mask,
                  input ready);
  modport sink (input valid, input mode, input target_id, input health_mask,
                output ready);
endinterface

`default_nettype wire

// File: src/sfs_rsp_if.sv
`default_nettype none

interface sfs_rsp_if;
  logic                           valid;
  logic                           ready;
  logic [sfs_pkg::StatusW-1:0]    status;
  logic [sfs_pkg::IdFieldW-1:0]   chosen_id;
  logic [sfs_pkg::SlotFieldW-1:0] chosen_slot;

  modport source (output valid, output status, output chosen_id, output chosen_slot,
                  input ready);
  modport sink (input valid, input status, input chosen_id, input chosen_slot,
                output ready);
endinterface

`default_nettype wire

// File: src/sfs_ctrl.sv
`default_nettype none

module sfs_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  input  wire sfs_pkg::sts_t sts_i,
  output sfs_pkg::cmd_t      cmd_o
);

  typedef enum logic [3:0] {
    SIdle,
    SDecode,
    SSrchRd,
    SSrchCmp,
    SShiftRd,
    SShiftWr,
    SScan,
    SFetch,
    SEmit
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  assign in_ready_o  = (state_q == SIdle);
  assign out_valid_o = out_valid_q;

  // Sequence one request through the datapath
  always_comb begin
    state_d         = state_q;
    cmd_o           = '0;
    cmd_o.op        = sfs_pkg::DpIdle;
    cmd_o.res       = sfs_pkg::StIgnored;
    out_valid_d     = out_valid_q && !out_ready_i;
    case (state_q)
      SIdle: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = SDecode;
        end
      end
      SDecode: begin
        case (sts_i.mode)
          sfs_pkg::ModeAdd: begin
            cmd_o.set_res = 1'b1;
            if (sts_i.id_zero) begin
              cmd_o.res = sfs_pkg::StIgnored;
            end else if (sts_i.full) begin
              cmd_o.res = sfs_pkg::StFull;
            end else begin
              cmd_o.op  = sfs_pkg::DpAppend;
              cmd_o.res = sfs_pkg::StAdded;
            end
            state_d = SEmit;
          end
          sfs_pkg::ModeRemove: begin
            if (sts_i.id_zero || sts_i.empty) begin
              cmd_o.set_res = 1'b1;
              cmd_o.res     = sfs_pkg::StIgnored;
              state_d       = SEmit;
            end else begin
              cmd_o.op = sfs_pkg::DpRemoveStart;
              state_d  = SSrchRd;
            end
          end
          sfs_pkg::ModeResolve: begin
            if (sts_i.empty) begin
              cmd_o.set_res = 1'b1;
              cmd_o.res     = sfs_pkg::StNone;
              state_d       = SEmit;
            end else begin
              cmd_o.op = sfs_pkg::DpScanStart;
              state_d  = SScan;
            end
          end
          default: begin
            cmd_o.set_res = 1'b1;
            cmd_o.res     = sfs_pkg::StIgnored;
            state_d       = SEmit;
          end
        endcase
      end
      SSrchRd: begin
        cmd_o.op = sfs_pkg::DpRead;
        state_d  = SSrchCmp;
      end
      SSrchCmp: begin
        if (sts_i.match) begin
          cmd_o.op = sfs_pkg::DpMark;
          state_d  = SShiftRd;
        end else if (sts_i.last) begin
          cmd_o.set_res = 1'b1;
          cmd_o.res     = sfs_pkg::StIgnored;
          state_d       = SEmit;
        end else begin
          cmd_o.op = sfs_pkg::DpNext;
          state_d  = SSrchRd;
        end
      end
      SShiftRd: begin
        // Close the gap one slot at a time, then shrink the list
        if (sts_i.last) begin
          cmd_o.op      = sfs_pkg::DpRemoveFix;
          cmd_o.set_res = 1'b1;
          cmd_o.res     = sfs_pkg::StRemoved;
          state_d       = SEmit;
        end else begin
          cmd_o.op = sfs_pkg::DpReadNext;
          state_d  = SShiftWr;
        end
      end
      SShiftWr: begin
        cmd_o.op = sfs_pkg::DpWrite;
        state_d  = SShiftRd;
      end
      SScan: begin
        if (sts_i.healthy) begin
          cmd_o.op = sfs_pkg::DpScanHit;
          state_d  = SFetch;
        end else if (sts_i.scan_last) begin
          cmd_o.set_res = 1'b1;
          cmd_o.res     = sfs_pkg::StNone;
          state_d       = SEmit;
        end else begin
          cmd_o.op = sfs_pkg::DpScanStep;
        end
      end
      SFetch: begin
        cmd_o.set_res = 1'b1;
        cmd_o.res     = sfs_pkg::StChosen;
        state_d       = SEmit;
      end
      SEmit: begin
        // Hold until the output register is free
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = SIdle;
        end
      end
      default: begin
        state_d = SIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

// File: src/sfs_datapath.sv
`default_nettype none

module sfs_datapath #(
  parameter int MAX_TARGETS = sfs_pkg::MaxTargetsDef,
  parameter int ID_BITS     = sfs_pkg::IdBitsDef
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire sfs_pkg::cmd_t                    cmd_i,
  output sfs_pkg::sts_t                         sts_o,
  input  wire logic [sfs_pkg::ModeW-1:0]        mode_i,
  input  wire logic [sfs_pkg::IdFieldW-1:0]     target_id_i,
  input  wire logic [sfs_pkg::MaskW-1:0]        health_mask_i,
  output sfs_pkg::status_e                      status_o,
  output logic [sfs_pkg::IdFieldW-1:0]          chosen_id_o,
  output logic [sfs_pkg::SlotFieldW-1:0]        chosen_slot_o
);

  localparam int IdxW = $clog2(MAX_TARGETS);
  localparam int CntW = $clog2(MAX_TARGETS + 1);
  localparam int IdW  = (ID_BITS < sfs_pkg::IdFieldW) ? ID_BITS : sfs_pkg::IdFieldW;
  localparam int PosW = (IdxW > sfs_pkg::SlotFieldW) ? IdxW : sfs_pkg::SlotFieldW;
  localparam logic [CntW-1:0] MaxCnt = CntW'(MAX_TARGETS);

  // Target list storage
  logic [IdW-1:0] mem_q [MAX_TARGETS];
  logic [IdW-1:0] rdata_q;

  logic [sfs_pkg::ModeW-1:0] mode_q;
  logic [IdW-1:0]            id_q;
  logic [sfs_pkg::MaskW-1:0] mask_q;

  logic [CntW-1:0] count_q, count_d, steps_q, count_dec, ptr_inc;
  logic [IdxW-1:0] cur_q, cur_d, ptr_q, pos_q, cur_norm, cur_dec;
  logic [PosW-1:0] ptr_ext, cur_ext;

  logic            wr_en, rd_en;
  logic [IdxW-1:0] wr_addr, rd_addr;
  logic [IdW-1:0]  wr_data;

  sfs_pkg::status_e                res_status_q, out_status_q;
  logic [sfs_pkg::IdFieldW-1:0]    res_id_q, out_id_q;
  logic [sfs_pkg::SlotFieldW-1:0]  res_slot_q, out_slot_q;

  assign ptr_inc   = CntW'(ptr_q) + CntW'(1);
  assign ptr_ext   = PosW'(ptr_q);
  assign cur_ext   = PosW'(cur_q);
  assign count_dec = count_q - CntW'(1);
  assign cur_norm  = (CntW'(cur_q) >= count_q) ? '0 : cur_q;
  assign cur_dec   = (pos_q < cur_q) ? cur_q - IdxW'(1) : cur_q;

  // Status toward the controller
  always_comb begin
    sts_o.mode      = sfs_pkg::mode_e'(mode_q);
    sts_o.id_zero   = (id_q == '0);
    sts_o.full      = (count_q == MaxCnt);
    sts_o.empty     = (count_q == '0);
    sts_o.match     = (rdata_q == id_q);
    sts_o.last      = (ptr_inc >= count_q);
    // slots beyond the mask width count as unhealthy
    sts_o.healthy   = ((ptr_ext >> sfs_pkg::SlotFieldW) == '0) &&
                      mask_q[ptr_ext[sfs_pkg::SlotFieldW-1:0]];
    sts_o.scan_last = ((steps_q + CntW'(1)) >= count_q);
  end

  // Memory port and list state updates
  always_comb begin
    count_d = count_q;
    cur_d   = cur_q;
    wr_en   = 1'b0;
    wr_addr = ptr_q;
    wr_data = rdata_q;
    rd_en   = 1'b0;
    rd_addr = ptr_q;
    case (cmd_i.op)
      sfs_pkg::DpAppend: begin
        wr_en   = 1'b1;
        wr_addr = count_q[IdxW-1:0];
        wr_data = id_q;
        count_d = count_q + CntW'(1);
      end
      sfs_pkg::DpScanStart: begin
        cur_d = cur_norm;
      end
      sfs_pkg::DpRead: begin
        rd_en = 1'b1;
      end
      sfs_pkg::DpReadNext: begin
        rd_en   = 1'b1;
        rd_addr = ptr_inc[IdxW-1:0];
      end
      sfs_pkg::DpWrite: begin
        wr_en = 1'b1;
      end
      sfs_pkg::DpRemoveFix: begin
        count_d = count_dec;
        // wrap the sticky slot when it falls off the end
        cur_d   = (CntW'(cur_dec) >= count_dec) ? '0 : cur_dec;
      end
      sfs_pkg::DpScanHit: begin
        cur_d = ptr_q;
        rd_en = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      cur_q   <= '0;
    end else begin
      count_q <= count_d;
      cur_q   <= cur_d;
    end
  end

  // Request capture, walk pointer, memory and result payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      mode_q <= mode_i;
      id_q   <= target_id_i[IdW-1:0];
      mask_q <= health_mask_i;
    end
    case (cmd_i.op)
      sfs_pkg::DpRemoveStart: ptr_q <= '0;
      sfs_pkg::DpScanStart: begin
        ptr_q   <= cur_norm;
        steps_q <= '0;
      end
      sfs_pkg::DpNext:  ptr_q <= ptr_inc[IdxW-1:0];
      sfs_pkg::DpMark:  pos_q <= ptr_q;
      sfs_pkg::DpWrite: ptr_q <= ptr_inc[IdxW-1:0];
      sfs_pkg::DpScanStep: begin
        steps_q <= steps_q + CntW'(1);
        ptr_q   <= sts_o.last ? '0 : ptr_inc[IdxW-1:0];
      end
      default: ;
    endcase
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_q <= mem_q[rd_addr];
    end
    if (cmd_i.set_res) begin
      res_status_q <= cmd_i.res;
      if (cmd_i.res == sfs_pkg::StChosen) begin
        res_id_q   <= sfs_pkg::IdFieldW'(rdata_q);
        res_slot_q <= cur_ext[sfs_pkg::SlotFieldW-1:0];
      end else begin
        res_id_q   <= '0;
        res_slot_q <= '0;
      end
    end
    if (cmd_i.load_out) begin
      out_status_q <= res_status_q;
      out_id_q     <= res_id_q;
      out_slot_q   <= res_slot_q;
    end
  end

  assign status_o      = out_status_q;
  assign chosen_id_o   = out_id_q;
  assign chosen_slot_o = out_slot_q;

endmodule

`default_nettype wire

// File: src/sticky_failover_selector.sv
// Channel   Dir  Handshake     Payload
// req_i     in   valid/ready   mode, target_id, health_mask
// rsp_o     out  valid/ready   status, chosen_id, chosen_slot
//
// One request at a time; N is the current list length.
// Add, and a request rejected at decode: settled in the decode step, then emitted.
// Resolve: one slot tested per cycle, plus one read of the list.
// Remove: a read and a compare per slot searched, then a read and a write per slot shifted.
// Reset clears the list length and the sticky slot; list entries start undefined.
// A held response stalls only the final step; the next request is taken meanwhile.
`default_nettype none
`include "sticky_failover_selector_defines.svh"

module sticky_failover_selector #(
  parameter int MAX_TARGETS = sfs_pkg::MaxTargetsDef,
  parameter int ID_BITS     = sfs_pkg::IdBitsDef
) (
  input wire logic   clk_i,
  input wire logic   rst_ni,
  sfs_req_if.sink    req_i,
  sfs_rsp_if.source  rsp_o
);

  sfs_pkg::cmd_t    cmd;
  sfs_pkg::sts_t    sts;
  sfs_pkg::status_e status;

  sfs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  sfs_datapath #(
    .MAX_TARGETS (MAX_TARGETS),
    .ID_BITS     (ID_BITS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .mode_i        (req_i.mode),
    .target_id_i   (req_i.target_id),
    .health_mask_i (req_i.health_mask),
    .status_o      (status),
    .chosen_id_o   (rsp_o.chosen_id),
    .chosen_slot_o (rsp_o.chosen_slot)
  );

  assign rsp_o.status = status;

  // One request in flight: no second acceptance right after one
  `SFS_ASSERT_NEXT(a_one_in_flight, clk_i, rst_ni, req_i.valid && req_i.ready, !req_i.ready, "request accepted while busy")
  // Never overwrite a response that is still waiting
  `SFS_ASSERT_IMPL(a_load_free, clk_i, rst_ni, cmd.load_out, !rsp_o.valid || rsp_o.ready, "response overwritten")
  // Append only with room and a nonzero ID
  `SFS_ASSERT_IMPL(a_append_ok, clk_i, rst_ni, cmd.op == sfs_pkg::DpAppend, !sts.full && !sts.id_zero, "bad append")

endmodule

`default_nettype wire

// File: tb/sv/tb_sticky_failover_selector.sv
`timescale 1ns / 100ps

module tb_sticky_failover_selector;
  import sfs_pkg::*;

  localparam int NumTargets   = MaxTargetsDef;
  localparam int IdW          = IdBitsDef;
  localparam int PhaseItems   = 450;
  localparam int LevelSpan    = 40;
  localparam int DrainCycles  = 64;
  localparam int CycleLimit   = 400000;
  // Mode code that the block leaves unused
  localparam logic [ModeW-1:0] ModeUnused = 2'd3;

  typedef struct packed {
    logic [ModeW-1:0]    mode;
    logic [IdFieldW-1:0] target_id;
    logic [MaskW-1:0]    health_mask;
  } sel_req_t;

  typedef struct packed {
    logic [StatusW-1:0]    status;
    logic [IdFieldW-1:0]   chosen_id;
    logic [SlotFieldW-1:0] chosen_slot;
  } sel_rsp_t;

  typedef struct packed {
    logic [NumTargets-1:0][IdW-1:0] list;
    logic [4:0]                     count;
    logic [3:0]                     cur;
  } sel_state_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  sfs_req_if req_if ();
  sfs_rsp_if rsp_if ();

  sticky_failover_selector u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  sel_req_t   pending_reqs[$];
  sel_rsp_t   expected_rsps[$];
  sel_state_t list_model;
  sel_state_t gen_model;
  int         send_idle_pct;
  int         recv_idle_pct;
  int         reqs_queued;
  int         reqs_taken;
  int         err_cnt;
  int         cycle_cnt;

  always #1 clk_i = ~clk_i;

  // Apply one request to a list state and return the response it causes
  function automatic sel_rsp_t apply_request(inout sel_state_t s, input sel_req_t r);
    sel_rsp_t o;
    int       hit;
    logic     done;
    o.status      = StIgnored;
    o.chosen_id   = '0;
    o.chosen_slot = '0;
    hit           = -1;
    done          = 1'b0;
    case (r.mode)
      ModeAdd: begin
        if (r.target_id != '0) begin
          if (s.count >= NumTargets) begin
            o.status = StFull;
          end else begin
            s.list[s.count[3:0]] = r.target_id[IdW-1:0];
            s.count              = s.count + 5'd1;
            o.status             = StAdded;
          end
        end
      end
      ModeRemove: begin
        if (r.target_id != '0) begin
          for (int k = 0; k < int'(s.count); k++)
            if (hit < 0 && s.list[k] == r.target_id[IdW-1:0]) hit = k;
          if (hit >= 0) begin
            // Close the gap and pull the sticky slot along
            for (int k = hit; k + 1 < int'(s.count); k++) s.list[k] = s.list[k+1];
            s.count = s.count - 5'd1;
            if (hit < int'(s.cur)) s.cur = s.cur - 4'd1;
            if (s.cur >= s.count) s.cur = '0;
            o.status = StRemoved;
          end
        end
      end
      ModeResolve: begin
        o.status = StNone;
        if (s.count != '0) begin
          if (s.cur >= s.count) s.cur = '0;
          for (int k = 0; k < int'(s.count); k++) begin
            if (!done) begin
              if (r.health_mask[s.cur]) begin
                done          = 1'b1;
                o.status      = StChosen;
                o.chosen_id   = IdFieldW'(s.list[s.cur]);
                o.chosen_slot = s.cur;
              end else begin
                s.cur = (5'(s.cur) + 5'd1 >= s.count) ? 4'd0 : s.cur + 4'd1;
              end
            end
          end
        end
      end
      default: ;
    endcase
    return o;
  endfunction

  // Queue a request and track the list it leaves behind for stimulus shaping
  task automatic queue_req(input logic [ModeW-1:0] mode, input logic [IdFieldW-1:0] id,
                           input logic [MaskW-1:0] mask);
    sel_req_t r;
    sel_rsp_t unused_rsp;
    r.mode        = mode;
    r.target_id   = id;
    r.health_mask = mask;
    unused_rsp    = apply_request(gen_model, r);
    pending_reqs.push_back(r);
    reqs_queued++;
  endtask

  // Random requests, steered toward a moving list fill level
  task automatic queue_random(input int n);
    int                  fill_goal;
    int                  pick;
    logic [ModeW-1:0]    mode;
    logic [IdFieldW-1:0] id;
    logic [MaskW-1:0]    mask;
    fill_goal = 0;
    for (int i = 0; i < n; i++) begin
      if (i % LevelSpan == 0)
        fill_goal = ($urandom_range(0, 3) == 0) ? NumTargets : $urandom_range(0, NumTargets);
      id   = IdFieldW'($urandom);
      mask = MaskW'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 2) begin
        mode = ModeUnused;
      end else if (pick < 40) begin
        mode = ModeResolve;
        pick = $urandom_range(0, 9);
        if (pick == 0) mask = '0;
        else if (pick == 1) mask = '1;
        else if (pick < 4) mask = MaskW'(1) << $urandom_range(0, MaskW - 1);
      end else begin
        pick = $urandom_range(0, 99);
        if ((int'(gen_model.count) < fill_goal) ? (pick < 75) : (pick < 25)) begin
          mode = ModeAdd;
          pick = $urandom_range(0, 99);
          if (pick < 3) id = '0;
          else if (pick < 70) id = IdFieldW'($urandom_range(1, 24));
        end else begin
          mode = ModeRemove;
          pick = $urandom_range(0, 99);
          if (pick < 3) id = '0;
          else if (pick < 75 && gen_model.count != '0)
            id = IdFieldW'(gen_model.list[$urandom_range(0, int'(gen_model.count) - 1)]);
          else if (pick < 90) id = IdFieldW'($urandom_range(1, 24));
        end
      end
      queue_req(mode, id, mask);
    end
  endtask

  task automatic wait_queue_empty();
    while (pending_reqs.size() != 0) @(posedge clk_i);
  endtask

  // Request driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
    end else if (!req_if.valid || req_if.ready) begin
      if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        sel_req_t r;
        r = pending_reqs.pop_front();
        req_if.valid       <= 1'b1;
        req_if.mode        <= r.mode;
        req_if.target_id   <= r.target_id;
        req_if.health_mask <= r.health_mask;
      end else begin
        req_if.valid <= 1'b0;
      end
    end
  end

  // Response back-pressure
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
    end else begin
      rsp_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  function automatic void check_field(input string name, input logic [31:0] exp_v,
                                      input logic [31:0] got_v);
    if (exp_v !== got_v) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $realtime, name, exp_v, got_v);
      err_cnt++;
    end
  endfunction

  // Predict on each accepted request, check each accepted response
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      list_model.list  <= '0;
      list_model.count <= '0;
      list_model.cur   <= '0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        sel_req_t   r;
        sel_state_t s;
        r.mode        = req_if.mode;
        r.target_id   = req_if.target_id;
        r.health_mask = req_if.health_mask;
        s             = list_model;
        expected_rsps.push_back(apply_request(s, r));
        list_model <= s;
        reqs_taken++;
      end
      if (rsp_if.valid && rsp_if.ready) begin
        if (expected_rsps.size() == 0) begin
          $display("%0t: unexpected response, expected none, actual %h/%h/%h", $realtime,
                   rsp_if.status, rsp_if.chosen_id, rsp_if.chosen_slot);
          err_cnt++;
        end else begin
          sel_rsp_t e;
          e = expected_rsps.pop_front();
          check_field("status", 32'(e.status), 32'(rsp_if.status));
          check_field("chosen_id", 32'(e.chosen_id), 32'(rsp_if.chosen_id));
          check_field("chosen_slot", 32'(e.chosen_slot), 32'(rsp_if.chosen_slot));
        end
      end
    end
  end

  // Hang guard
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("tb_sticky_failover_selector: FAIL");
      $finish;
    end
  end

  initial begin
    rst_ni             = 1'b0;
    req_if.valid       = 1'b0;
    req_if.mode        = ModeAdd;
    req_if.target_id   = '0;
    req_if.health_mask = '0;
    rsp_if.ready       = 1'b0;
    cycle_cnt          = 0;
    err_cnt            = 0;
    reqs_queued        = 0;
    reqs_taken         = 0;
    send_idle_pct      = 9;
    recv_idle_pct      = 55;
    gen_model          = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Empty list, zero IDs, unused mode, remove miss
    queue_req(ModeResolve, 16'h1234, 16'hFFFF);
    queue_req(ModeAdd, 16'h0000, 16'h0000);
    queue_req(ModeRemove, 16'h0000, 16'hFFFF);
    queue_req(ModeRemove, 16'h00AA, 16'h0000);
    queue_req(ModeUnused, 16'hFFFF, 16'hFFFF);
    // Extreme IDs and a duplicate
    queue_req(ModeAdd, 16'hFFFF, 16'h0000);
    queue_req(ModeAdd, 16'h0001, 16'hFFFF);
    queue_req(ModeAdd, 16'h8000, 16'h0000);
    queue_req(ModeAdd, 16'h0001, 16'h0000);
    // No healthy slot, then plain hit, wrap-around hit and sticky hit
    queue_req(ModeResolve, 16'h0000, 16'h0000);
    queue_req(ModeResolve, 16'h0000, 16'h0004);
    queue_req(ModeResolve, 16'hFFFF, 16'h0001);
    queue_req(ModeResolve, 16'h0000, 16'hFFFF);
    queue_req(ModeResolve, 16'h0000, 16'h8008);
    // Remove before the sticky slot, then at the end of the list
    queue_req(ModeRemove, 16'h0001, 16'h0000);
    queue_req(ModeRemove, 16'h0001, 16'h0000);
    queue_req(ModeResolve, 16'h0000, 16'hFFFF);
    // Drain the list to empty
    queue_req(ModeRemove, 16'hFFFF, 16'h0000);
    queue_req(ModeRemove, 16'h8000, 16'h0000);
    queue_req(ModeResolve, 16'h0000, 16'hFFFF);
    queue_random(PhaseItems);
    wait_queue_empty();

    send_idle_pct = 55;
    recv_idle_pct = 9;
    queue_random(PhaseItems);
    wait_queue_empty();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    queue_random(PhaseItems);

    // Let everything drain, then give the block time to go quiet
    while (reqs_taken != reqs_queued) @(posedge clk_i);
    while (expected_rsps.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (err_cnt == 0 && expected_rsps.size() == 0) begin
      $display("tb_sticky_failover_selector: PASS");
    end else begin
      $display("tb_sticky_failover_selector: FAIL");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+src
src/sfs_pkg.sv
src/sfs_req_if.sv
src/sfs_rsp_if.sv
src/sfs_ctrl.sv
src/sfs_datapath.sv
src/sticky_failover_selector.sv
tb/sv/tb_sticky_failover_selector.sv
